[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define MER_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define MER_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[rtl/mer_pkg.sv]
// Types, widths and command/status structs of the ellipse rasterizer.
// No dependencies; used by every other file of the block but assert_macros.svh.
package mer_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int RADIUS_WIDTH = 10;
   localparam int PIX_WIDTH    = COORD_WIDTH + 1;
   localparam int STEP_WIDTH   = RADIUS_WIDTH + 2;
   localparam int SQ_WIDTH     = 2 * RADIUS_WIDTH;
   localparam int OPA_WIDTH    = SQ_WIDTH + 1;
   localparam int OPB_WIDTH    = RADIUS_WIDTH + 4;
   localparam int PROD_WIDTH   = OPA_WIDTH + OPB_WIDTH;
   localparam int DEC_WIDTH    = PROD_WIDTH + 3;
   localparam int SUM_WIDTH    =
      ((COORD_WIDTH > STEP_WIDTH) ? COORD_WIDTH : STEP_WIDTH) + 1;

   localparam logic [1:0] QUAD_LAST = 2'b11;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      REGION_IDLE,
      REGION_ONE,
      REGION_TWO
   } region_type;

   typedef enum logic [2:0] {
      MUL_AA,
      MUL_BB,
      MUL_VW,
      MUL_UU,
      MUL_VV,
      MUL_U2,
      MUL_V1
   } mul_sel_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_PIXEL,
      OUT_FINISH
   } out_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQ_C,
      ST_INIT_M,
      ST_INIT_D,
      ST_TEST_U,
      ST_TEST_V,
      ST_TEST_C,
      ST_INC_1,
      ST_INC_2,
      ST_ENTER_TWO,
      ST_EMIT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic         take_req;
      mul_sel_type  mul_sel;
      logic         load_a_sq;
      logic         load_b_sq;
      logic         load_t;
      logic         load_neg;
      logic         init_dec;
      logic         add_inc;
      logic         add_corr;
      logic         enter_two;
      logic         set_idle;
      out_kind_type out_kind;
      logic [1:0]   quad;
   } dp_cmd_type;

   typedef struct packed {
      logic       is_start;
      logic       bad_radius;
      region_type region;
      logic       test_pass;
      logic       out_free;
   } dp_status_type;

endpackage

[rtl/mer_req_if.sv]
// Request channel: valid/ready handshake carrying one command beat.
// Depends on mer_pkg for field widths.
interface mer_req_if;
   import mer_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           command;
   logic signed [COORD_WIDTH-1:0]  center_x;
   logic signed [COORD_WIDTH-1:0]  center_y;
   logic        [RADIUS_WIDTH-1:0] radius_a;
   logic        [RADIUS_WIDTH-1:0] radius_b;

   modport source (output valid, command, center_x, center_y, radius_a, radius_b,
                   input ready);
   modport sink   (input valid, command, center_x, center_y, radius_a, radius_b,
                   output ready);
endinterface

[rtl/mer_rsp_if.sv]
// Response channel: valid/ready handshake carrying one pixel or status beat.
// Depends on mer_pkg for field widths.
interface mer_rsp_if;
   import mer_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [PIX_WIDTH-1:0] pixel_x;
   logic signed [PIX_WIDTH-1:0] pixel_y;
   logic                        pixel_valid;
   logic                        last_of_run;
   logic                        finished;
   logic                        bad_radius;

   modport source (output valid, pixel_x, pixel_y, pixel_valid, last_of_run,
                   finished, bad_radius, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_of_run,
                   finished, bad_radius, output ready);
endinterface

[rtl/midpoint_ellipse_rasterizer_unit.sv]
// Midpoint ellipse rasterizer: one command beat in, one to four beats out.
// Start: a finished beat if a radius is zero, else pixels once the radii are
// squared and the decision set up, one beat a cycle while the output is free;
// next command taken after the last beat. Step: a decision test and update, a
// switch to region two, or a finished beat; one shared 21x14 multiplier.
// Reset (synchronous, active high) idles the sequencer and empties the output.
module midpoint_ellipse_rasterizer_unit (
   input  logic      clock,
   input  logic      reset,
   mer_req_if.sink   req_bus,
   mer_rsp_if.source rsp_bus
);
   import mer_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mer_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_bus.command),
      .req_center_x    (req_bus.center_x),
      .req_center_y    (req_bus.center_y),
      .req_radius_a    (req_bus.radius_a),
      .req_radius_b    (req_bus.radius_b),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_pixel_x     (rsp_bus.pixel_x),
      .rsp_pixel_y     (rsp_bus.pixel_y),
      .rsp_pixel_valid (rsp_bus.pixel_valid),
      .rsp_last_of_run (rsp_bus.last_of_run),
      .rsp_finished    (rsp_bus.finished),
      .rsp_bad_radius  (rsp_bus.bad_radius)
   );

endmodule

[rtl/mer_ctrl.sv]
// Sequencer of the ellipse rasterizer: walks the multiply/update steps
// and the four output beats. Depends on mer_pkg.
module mer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mer_pkg::dp_status_type status,
   output mer_pkg::dp_cmd_type    cmd
);
   import mer_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   logic [1:0] quad_ff;
   logic [1:0] quad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         quad_ff  <= '0;
      end else begin
         state_ff <= state_in;
         quad_ff  <= quad_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      quad_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.is_start) begin
                  state_in = status.bad_radius ? ST_FIN : ST_SQ_A;
               end else if (status.region == REGION_IDLE) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_TEST_U;
               end
            end
         end
         ST_SQ_A:      state_in = ST_SQ_B;
         ST_SQ_B:      state_in = ST_SQ_C;
         ST_SQ_C:      state_in = ST_INIT_M;
         ST_INIT_M:    state_in = ST_INIT_D;
         ST_INIT_D:    state_in = ST_EMIT;
         ST_TEST_U:    state_in = ST_TEST_V;
         ST_TEST_V:    state_in = ST_TEST_C;
         ST_TEST_C: begin
            if (status.test_pass) begin
               state_in = ST_INC_1;
            end else if (status.region == REGION_ONE) begin
               state_in = ST_ENTER_TWO;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_INC_1:     state_in = ST_INC_2;
         ST_INC_2:     state_in = ST_EMIT;
         ST_ENTER_TWO: state_in = ST_INIT_M;
         ST_EMIT: begin
            quad_in = quad_ff;
            if (status.out_free) begin
               quad_in = quad_ff + 2'd1;
               if (quad_ff == QUAD_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.quad  = quad_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         ST_SQ_A: cmd.mul_sel = MUL_AA;
         ST_SQ_B: begin
            cmd.mul_sel   = MUL_BB;
            cmd.load_a_sq = 1'b1;
         end
         ST_SQ_C:   cmd.load_b_sq = 1'b1;
         ST_INIT_M: cmd.mul_sel = MUL_VW;
         ST_INIT_D: cmd.init_dec = 1'b1;
         ST_TEST_U: cmd.mul_sel = MUL_UU;
         ST_TEST_V: begin
            cmd.mul_sel = MUL_VV;
            cmd.load_t  = 1'b1;
         end
         ST_TEST_C: begin
            cmd.mul_sel  = MUL_U2;
            cmd.load_neg = 1'b1;
         end
         ST_INC_1: begin
            cmd.mul_sel = MUL_V1;
            cmd.add_inc = 1'b1;
         end
         ST_INC_2:     cmd.add_corr = 1'b1;
         ST_ENTER_TWO: cmd.enter_two = 1'b1;
         ST_EMIT: begin
            cmd.out_kind = status.out_free ? OUT_PIXEL : OUT_NONE;
         end
         ST_FIN: begin
            cmd.out_kind = status.out_free ? OUT_FINISH : OUT_NONE;
            cmd.set_idle = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/mer_dp.sv]
// Datapath of the ellipse rasterizer: held ellipse, shared multiplier,
// decision accumulator and the response register. Depends on mer_pkg.
module mer_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mer_pkg::dp_cmd_type                  cmd,
   output mer_pkg::dp_status_type               status,
   input  logic                                 req_command,
   input  logic signed [mer_pkg::COORD_WIDTH-1:0]  req_center_x,
   input  logic signed [mer_pkg::COORD_WIDTH-1:0]  req_center_y,
   input  logic        [mer_pkg::RADIUS_WIDTH-1:0] req_radius_a,
   input  logic        [mer_pkg::RADIUS_WIDTH-1:0] req_radius_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mer_pkg::PIX_WIDTH-1:0] rsp_pixel_x,
   output logic signed [mer_pkg::PIX_WIDTH-1:0] rsp_pixel_y,
   output logic                                 rsp_pixel_valid,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_finished,
   output logic                                 rsp_bad_radius
);
   import mer_pkg::*;

   logic signed [COORD_WIDTH-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic        [RADIUS_WIDTH-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic        [SQ_WIDTH-1:0]     a_sq_ff, a_sq_in, b_sq_ff, b_sq_in;
   logic signed [STEP_WIDTH-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [DEC_WIDTH-1:0]    dec_ff, dec_in;
   region_type                     region_ff, region_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in, t_ff, t_in;
   logic                           neg_ff, neg_in, bad_ff, bad_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_WIDTH-1:0]    px_ff, px_in, py_ff, py_in;
   logic                           pv_ff, pv_in, last_ff, last_in;
   logic                           fin_ff, fin_in, badr_ff, badr_in;

   logic                           in_two, start_cmd, bad_req;
   logic signed [STEP_WIDTH-1:0]   u_val, v_val;
   logic        [SQ_WIDTH-1:0]     u_sq, v_sq;
   logic        [RADIUS_WIDTH-1:0] w_rad;
   logic signed [OPA_WIDTH-1:0]    opa;
   logic signed [OPB_WIDTH-1:0]    opb;
   logic signed [DEC_WIDTH-1:0]    u_sq_d, v_sq_d, prod_d;
   logic signed [SUM_WIDTH-1:0]    cx_s, cy_s, x_s, y_s, px_sum, py_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= REGION_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      a_sq_ff <= a_sq_in;
      b_sq_ff <= b_sq_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      dec_ff  <= dec_in;
      prod_ff <= prod_in;
      t_ff    <= t_in;
      neg_ff  <= neg_in;
      bad_ff  <= bad_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      pv_ff   <= pv_in;
      last_ff <= last_in;
      fin_ff  <= fin_in;
      badr_ff <= badr_in;
   end

   // Region two swaps the roles of the axes: u steps up, v steps down.
   assign in_two    = (region_ff == REGION_TWO);
   assign u_val     = in_two ? y_ff : x_ff;
   assign v_val     = in_two ? x_ff : y_ff;
   assign u_sq      = in_two ? a_sq_ff : b_sq_ff;
   assign v_sq      = in_two ? b_sq_ff : a_sq_ff;
   assign w_rad     = in_two ? ra_ff : rb_ff;
   assign start_cmd = (req_command == CMD_START);
   assign bad_req   = (req_radius_a == '0) || (req_radius_b == '0);

   always_comb begin
      case (cmd.mul_sel)
         MUL_AA: begin
            opa = OPA_WIDTH'(ra_ff);
            opb = OPB_WIDTH'(ra_ff);
         end
         MUL_BB: begin
            opa = OPA_WIDTH'(rb_ff);
            opb = OPB_WIDTH'(rb_ff);
         end
         MUL_VW: begin
            opa = OPA_WIDTH'(v_sq);
            opb = OPB_WIDTH'(w_rad);
         end
         MUL_UU: begin
            opa = OPA_WIDTH'(u_sq);
            opb = OPB_WIDTH'(u_val);
         end
         MUL_VV: begin
            opa = OPA_WIDTH'(v_sq);
            opb = OPB_WIDTH'(v_val);
         end
         MUL_U2: begin
            opa = OPA_WIDTH'(u_sq);
            opb = (OPB_WIDTH'(u_val) <<< 1) + OPB_WIDTH'(3);
         end
         MUL_V1: begin
            opa = OPA_WIDTH'(v_sq);
            opb = OPB_WIDTH'(1) - OPB_WIDTH'(v_val);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod_in = opa * opb;
   assign u_sq_d  = DEC_WIDTH'(u_sq);
   assign v_sq_d  = DEC_WIDTH'(v_sq);
   assign prod_d  = DEC_WIDTH'(prod_ff);

   always_comb begin
      status.is_start   = start_cmd;
      status.bad_radius = bad_req;
      status.region     = region_ff;
      status.test_pass  = in_two ? (t_ff < prod_ff) : (t_ff <= prod_ff);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // ellipse state
   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      a_sq_in   = cmd.load_a_sq ? SQ_WIDTH'(prod_ff) : a_sq_ff;
      b_sq_in   = cmd.load_b_sq ? SQ_WIDTH'(prod_ff) : b_sq_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      region_in = region_ff;
      t_in      = cmd.load_t ? prod_ff : t_ff;
      neg_in    = cmd.load_neg ? dec_ff[DEC_WIDTH-1] : neg_ff;
      bad_in    = bad_ff;
      if (cmd.take_req) begin
         bad_in = start_cmd && bad_req;
         if (start_cmd) begin
            cx_in     = req_center_x;
            cy_in     = req_center_y;
            ra_in     = req_radius_a;
            rb_in     = req_radius_b;
            x_in      = '0;
            y_in      = STEP_WIDTH'(req_radius_b);
            region_in = bad_req ? REGION_IDLE : REGION_ONE;
         end
      end
      if (cmd.init_dec) begin
         dec_in = (u_sq_d <<< 1) - (prod_d <<< 1) + v_sq_d;
      end
      if (cmd.add_inc) begin
         dec_in = dec_ff + (prod_d <<< 1);
      end
      if (cmd.add_corr) begin
         if (!neg_ff) begin
            dec_in = dec_ff + (prod_d <<< 2);
         end
         if (in_two) begin
            y_in = y_ff + STEP_WIDTH'(1);
            if (!neg_ff) begin
               x_in = x_ff - STEP_WIDTH'(1);
            end
         end else begin
            x_in = x_ff + STEP_WIDTH'(1);
            if (!neg_ff) begin
               y_in = y_ff - STEP_WIDTH'(1);
            end
         end
      end
      if (cmd.enter_two) begin
         region_in = REGION_TWO;
         x_in      = STEP_WIDTH'(ra_ff);
         y_in      = '0;
      end
      if (cmd.set_idle) begin
         region_in = REGION_IDLE;
      end
   end

   // quad bit 0 mirrors x, bit 1 mirrors y
   assign cx_s   = SUM_WIDTH'(cx_ff);
   assign cy_s   = SUM_WIDTH'(cy_ff);
   assign x_s    = SUM_WIDTH'(x_ff);
   assign y_s    = SUM_WIDTH'(y_ff);
   assign px_sum = cmd.quad[0] ? (cx_s - x_s) : (cx_s + x_s);
   assign py_sum = cmd.quad[1] ? (cy_s - y_s) : (cy_s + y_s);

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      px_in        = px_ff;
      py_in        = py_ff;
      pv_in        = pv_ff;
      last_in      = last_ff;
      fin_in       = fin_ff;
      badr_in      = badr_ff;
      case (cmd.out_kind)
         OUT_PIXEL: begin
            rsp_valid_in = 1'b1;
            px_in        = px_sum[PIX_WIDTH-1:0];
            py_in        = py_sum[PIX_WIDTH-1:0];
            pv_in        = 1'b1;
            last_in      = (cmd.quad == QUAD_LAST);
            fin_in       = 1'b0;
            badr_in      = 1'b0;
         end
         OUT_FINISH: begin
            rsp_valid_in = 1'b1;
            px_in        = '0;
            py_in        = '0;
            pv_in        = 1'b0;
            last_in      = 1'b1;
            fin_in       = 1'b1;
            badr_in      = bad_ff;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_valid = pv_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_finished    = fin_ff;
   assign rsp_bad_radius  = badr_ff;

endmodule

[rtl/mer_checker.sv]
// Port-level checks of the ellipse rasterizer, bound to the top level.
// Depends on mer_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mer_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [mer_pkg::PIX_WIDTH-1:0] rsp_pixel_x,
   input logic signed [mer_pkg::PIX_WIDTH-1:0] rsp_pixel_y,
   input logic                                 rsp_pixel_valid,
   input logic                                 rsp_last_of_run,
   input logic                                 rsp_finished,
   input logic                                 rsp_bad_radius
);
   import mer_pkg::*;

   // a beat without a pixel always closes the ellipse
   `MER_ASSERT(a_status_beat, rsp_valid && !rsp_pixel_valid |-> rsp_finished && rsp_last_of_run, "status beat without finished/last")
   `MER_ASSERT(a_bad_is_final, rsp_valid && rsp_bad_radius |-> rsp_finished && !rsp_pixel_valid, "bad radius on a pixel beat")
   `MER_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second command taken while busy")
   `MER_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last_of_run), "stalled beat changed")
   `MER_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "output not empty after reset")

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pixel_x     (rsp_bus.pixel_x),
   .rsp_pixel_y     (rsp_bus.pixel_y),
   .rsp_pixel_valid (rsp_bus.pixel_valid),
   .rsp_last_of_run (rsp_bus.last_of_run),
   .rsp_finished    (rsp_bus.finished),
   .rsp_bad_radius  (rsp_bus.bad_radius)
);
